@@ design/tcw_pkg.sv @@
// Shared constants, types and state encoding for the text console character writer.
// Used by the screen RAM and the top level. No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STEP   = 8;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int SCROLL_LEN = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(ROWS + 2);

  localparam logic [7:0]  CODE_NEWLINE = 8'd10;
  localparam logic [7:0]  CODE_RETURN  = 8'd13;
  localparam logic [7:0]  CODE_TAB     = 8'd9;
  localparam logic [15:0] BLANK_CELL   = 16'h0220;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef logic [ADDR_W-1:0] cell_addr_t;

  typedef struct packed {
    logic       we;
    cell_addr_t addr;
    logic [15:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic       re;
    cell_addr_t addr;
  } ram_rd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_ZERO,
    ST_EXEC,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

@@ design/tcw_in_if.sv @@
// Input channel of the console writer: valid/ready handshake with one item per beat.
// Depends on nothing but its own declarations.
`default_nettype none

interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  character;
  logic [10:0] cell_index;

  modport source (output valid, operation, character, cell_index, input ready);
  modport sink   (input valid, operation, character, cell_index, output ready);
endinterface

`default_nettype wire

@@ design/tcw_out_if.sv @@
// Result channel of the console writer: valid/ready handshake with one result per beat.
// Depends on nothing but its own declarations.
`default_nettype none

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [4:0]  cursor_row;
  logic [7:0]  cursor_column;
  logic [15:0] cursor_position;

  modport source (output valid, read_data, cursor_row, cursor_column, cursor_position,
                  input ready);
  modport sink   (input valid, read_data, cursor_row, cursor_column, cursor_position,
                  output ready);
endinterface

`default_nettype wire

@@ design/tcw_screen_ram.sv @@
// Screen cell store: one write port and one read port with registered read data.
// Depends on tcw_pkg for the depth and the port structs.
`default_nettype none

module tcw_screen_ram (
  input  wire logic            clk,
  input  wire tcw_pkg::ram_wr_t wr,
  input  wire tcw_pkg::ram_rd_t rd,
  output logic [15:0]          rd_data
);

  logic [15:0] mem [tcw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

@@ design/text_console_char_writer.sv @@
// Text console character writer: screen store in a RAM plus a cursor sequencer.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if and tcw_screen_ram.
//
// Usage: each beat on in_ch either writes one character or control code (operation 0)
// or reads one screen cell (operation 1). Every item gives exactly one beat on
// out_ch with the cell read (0 for writes and out-of-range reads) and the cursor
// after the item. cfg_we with cfg_wdata sets the attribute byte of written cells;
// write it only while no item is in flight.
// Flow per item: a read passes the READ state and the registered RAM read, a write
// passes the EXEC state, and both then wait in FIN for the result register; a
// carriage return also zeroes its row in ZERO between EXEC and FIN. An item that
// overruns the last row first scrolls the screen, copying the RAM up one row in
// SCROLL and then zeroing the last row in ZERO, before EXEC. All of this runs
// through the single write port of the screen RAM, one cell per cycle. Items are
// handled one at a time.
// Reset: the cursor returns to the top left and the RAM is swept to the blank cell
// value, one cell per cycle across all ROWS*COLUMNS (2000) cells; in_ch.ready stays
// low during the sweep.
// Stall: a finished result waits in the output register while the next item is
// accepted and worked on; that item completes once the register has drained.
`default_nettype none

module text_console_char_writer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tcw_in_if.sink           in_ch,
  tcw_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int CNT_W  = tcw_pkg::CNT_W;
  localparam int ADDR_W = tcw_pkg::ADDR_W;

  tcw_pkg::state_t state_r, state_nxt;

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              zero_exec_r, zero_exec_nxt;
  logic [7:0]        attr_r;

  logic              op_r;
  logic [7:0]        char_r;
  logic [10:0]       idx_r;

  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic [4:0]        out_row_r;
  logic [7:0]        out_col_r;
  logic [15:0]       out_pos_r;

  tcw_pkg::ram_wr_t  ram_wr;
  tcw_pkg::ram_rd_t  ram_rd;
  logic [15:0]       ram_rd_data;

  logic              in_fire;
  logic              out_free;
  logic              col_ovf;
  logic [ROW_W-1:0]  row_wrap;
  logic [7:0]        col_wrap;
  logic [15:0]       pos;
  logic              idx_ok;

  tcw_screen_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (ram_rd_data)
  );

  assign in_ch.ready = (state_r == tcw_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign col_ovf  = (col_r >= 8'(tcw_pkg::COLUMNS));
  assign row_wrap = col_ovf ? row_r + ROW_W'(1) : row_r;
  assign col_wrap = col_ovf ? col_r - 8'(tcw_pkg::COLUMNS) : col_r;
  assign pos      = 16'(32'(row_r) * 32'(tcw_pkg::COLUMNS) + 32'(col_r));
  assign idx_ok   = (32'(idx_r) < 32'(tcw_pkg::CELL_COUNT));

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    zero_exec_nxt = zero_exec_r;
    case (state_r)
      tcw_pkg::ST_CLEAR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(tcw_pkg::CELL_COUNT - 1)) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.operation == tcw_pkg::OP_READ) begin
            state_nxt = tcw_pkg::ST_READ;
          end else begin
            col_nxt = col_wrap;
            if (row_wrap >= ROW_W'(tcw_pkg::ROWS)) begin
              row_nxt   = ROW_W'(tcw_pkg::ROWS - 1);
              cnt_nxt   = '0;
              state_nxt = tcw_pkg::ST_SCROLL;
            end else begin
              row_nxt   = row_wrap;
              state_nxt = tcw_pkg::ST_EXEC;
            end
          end
        end
      end
      tcw_pkg::ST_READ: begin
        state_nxt = tcw_pkg::ST_FIN;
      end
      tcw_pkg::ST_SCROLL: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(tcw_pkg::SCROLL_LEN)) begin
          cnt_nxt       = '0;
          base_nxt      = ADDR_W'(tcw_pkg::SCROLL_LEN);
          zero_exec_nxt = 1'b1;
          state_nxt     = tcw_pkg::ST_ZERO;
        end
      end
      tcw_pkg::ST_ZERO: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(tcw_pkg::COLUMNS - 1)) begin
          state_nxt = zero_exec_r ? tcw_pkg::ST_EXEC : tcw_pkg::ST_FIN;
        end
      end
      tcw_pkg::ST_EXEC: begin
        state_nxt = tcw_pkg::ST_FIN;
        if (char_r == tcw_pkg::CODE_NEWLINE) begin
          row_nxt = row_r + ROW_W'(1);
          col_nxt = '0;
        end else if (char_r == tcw_pkg::CODE_RETURN) begin
          col_nxt       = '0;
          cnt_nxt       = '0;
          base_nxt      = ADDR_W'(32'(row_r) * 32'(tcw_pkg::COLUMNS));
          zero_exec_nxt = 1'b0;
          state_nxt     = tcw_pkg::ST_ZERO;
        end else if (char_r == tcw_pkg::CODE_TAB) begin
          col_nxt = col_r + 8'(tcw_pkg::TAB_STEP);
        end else if (!col_ovf) begin
          col_nxt = col_r + 8'd1;
        end
      end
      tcw_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_wr      = '0;
    ram_rd      = '0;
    case (state_r)
      tcw_pkg::ST_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = ADDR_W'(cnt_r);
        ram_wr.data = tcw_pkg::BLANK_CELL;
      end
      tcw_pkg::ST_READ: begin
        ram_rd.re   = 1'b1;
        ram_rd.addr = ADDR_W'(idx_r);
      end
      tcw_pkg::ST_SCROLL: begin
        ram_rd.re   = (cnt_r != CNT_W'(tcw_pkg::SCROLL_LEN));
        ram_rd.addr = ADDR_W'(cnt_r + CNT_W'(tcw_pkg::COLUMNS));
        ram_wr.we   = (cnt_r != '0);
        ram_wr.addr = ADDR_W'(cnt_r - CNT_W'(1));
        ram_wr.data = ram_rd_data;
      end
      tcw_pkg::ST_ZERO: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = base_r + ADDR_W'(cnt_r);
        ram_wr.data = '0;
      end
      tcw_pkg::ST_EXEC: begin
        ram_wr.we   = (char_r != tcw_pkg::CODE_NEWLINE) && (char_r != tcw_pkg::CODE_RETURN) &&
                      (char_r != tcw_pkg::CODE_TAB) && !col_ovf;
        ram_wr.addr = ADDR_W'(32'(row_r) * 32'(tcw_pkg::COLUMNS) + 32'(col_r));
        ram_wr.data = {attr_r, char_r};
      end
      default: begin
        ram_wr = '0;
        ram_rd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      base_r      <= '0;
      zero_exec_r <= 1'b0;
      attr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      base_r      <= base_nxt;
      zero_exec_r <= zero_exec_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if (state_r == tcw_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_ch.operation;
      char_r <= in_ch.character;
      idx_r  <= in_ch.cell_index;
    end
    if (state_r == tcw_pkg::ST_FIN && out_free) begin
      out_data_r <= (op_r == tcw_pkg::OP_READ && idx_ok) ? ram_rd_data : 16'd0;
      out_row_r  <= 5'(row_r);
      out_col_r  <= col_r;
      out_pos_r  <= pos;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_data_r;
  assign out_ch.cursor_row      = out_row_r;
  assign out_ch.cursor_column   = out_col_r;
  assign out_ch.cursor_position = out_pos_r;

endmodule

`default_nettype wire
